// File: rtl/task_slot_list_priority_pick_top_defines.svh
// assertion macros used by the rtl
`ifndef TASK_SLOT_LIST_PRIORITY_PICK_TOP_DEFINES_SVH
`define TASK_SLOT_LIST_PRIORITY_PICK_TOP_DEFINES_SVH

// same-cycle implication
`define TSPP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSPP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tspp_pkg.sv
package tspp_pkg;

   localparam int ID_W = 8;
   localparam int PRIO_W = 8;
   localparam logic [ID_W-1:0] EMPTY_ID = 8'hFF;
   localparam logic [PRIO_W-1:0] NO_PRIO = 8'hFF;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_POP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } slot_type;

endpackage

// File: rtl/tspp_req_if.sv
interface tspp_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [tspp_pkg::ID_W-1:0]   task_id;
   logic [tspp_pkg::PRIO_W-1:0] task_priority;

   modport source (output valid, output opcode, output task_id, output task_priority,
                   input ready);
   modport sink (input valid, input opcode, input task_id, input task_priority,
                 output ready);
endinterface

// File: rtl/tspp_rsp_if.sv
interface tspp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic                      table_empty;
   logic                      picked_valid;
   logic [tspp_pkg::ID_W-1:0] picked_id;

   modport source (output valid, output found, output table_empty, output picked_valid,
                   output picked_id, input ready);
   modport sink (input valid, input found, input table_empty, input picked_valid,
                 input picked_id, output ready);
endinterface

// File: rtl/tspp_cell.sv
module tspp_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  tspp_pkg::slot_type d_in,
   output tspp_pkg::slot_type q
);

   logic [tspp_pkg::ID_W-1:0]   id_ff;
   logic [tspp_pkg::PRIO_W-1:0] prio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= tspp_pkg::EMPTY_ID;
      end else if (shift) begin
         id_ff <= d_in.id;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         prio_ff <= d_in.prio;
      end
   end

   assign q.id   = id_ff;
   assign q.prio = prio_ff;

endmodule

// File: rtl/task_slot_list_priority_pick_top.sv
// Task slot table of SLOT_COUNT slots held in a ring of cells that, during a scan or clearing
// pass, rotates one slot per clock past a single head compare unit. An operation is accepted
// only while the block is idle; add, remove and query take one full rotation, and pop takes
// two (one to find the lowest priority value, one to empty every slot holding the picked id),
// after which the result is registered. The result waits in an output
// register, so a new operation can be accepted while the previous result is not yet taken.
// Ids are 8 bits with 255 meaning empty; a slot with priority 255 is never popped.
`include "task_slot_list_priority_pick_top_defines.svh"

module task_slot_list_priority_pick_top #(
   parameter int SLOT_COUNT = 8
) (
   input logic       clock,
   input logic       reset,
   tspp_req_if.sink  req_ch,
   tspp_rsp_if.source rsp_ch
);

   localparam int CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   tspp_pkg::state_type state_ff, state_in;
   tspp_pkg::slot_type  cell_q [SLOT_COUNT];
   tspp_pkg::slot_type  head, tail_in;

   logic [CNT_W-1:0]             cnt_ff;
   tspp_pkg::op_type             op_ff;
   logic [tspp_pkg::ID_W-1:0]    id_ff;
   logic [tspp_pkg::PRIO_W-1:0]  prio_ff;
   logic                         flag_ff, flag_in;
   logic                         any_ff, any_in;
   logic [tspp_pkg::PRIO_W-1:0]  best_ff, best_in;
   logic [tspp_pkg::ID_W-1:0]    best_id_ff, best_id_in;

   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic                         rsp_empty_ff;
   logic                         rsp_pvalid_ff;
   logic [tspp_pkg::ID_W-1:0]    rsp_pid_ff;

   logic shift, accept, last, rsp_free, load_rsp, id_ok, hit, occ, pick_ok;

   // ring of slot cells
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      tspp_pkg::slot_type d;
      if (i == SLOT_COUNT - 1) begin : g_tail
         assign d = tail_in;
      end else begin : g_link
         assign d = cell_q[i+1];
      end
      tspp_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d_in  (d),
         .q     (cell_q[i])
      );
   end

   assign head     = cell_q[0];
   assign last     = (cnt_ff == CNT_W'(SLOT_COUNT - 1));
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && req_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tspp_pkg::ST_IDLE: begin
            if (req_ch.valid) state_in = tspp_pkg::ST_SCAN;
         end
         tspp_pkg::ST_SCAN: begin
            if (last) begin
               state_in = (op_ff == tspp_pkg::OP_POP) ? tspp_pkg::ST_CLEAR
                                                      : tspp_pkg::ST_FINISH;
            end
         end
         tspp_pkg::ST_CLEAR: begin
            if (last) state_in = tspp_pkg::ST_FINISH;
         end
         tspp_pkg::ST_FINISH: begin
            if (rsp_free) state_in = tspp_pkg::ST_IDLE;
         end
         default: state_in = tspp_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ch.ready = 1'b0;
      shift        = 1'b0;
      load_rsp     = 1'b0;
      case (state_ff)
         tspp_pkg::ST_IDLE:   req_ch.ready = 1'b1;
         tspp_pkg::ST_SCAN:   shift = 1'b1;
         tspp_pkg::ST_CLEAR:  shift = 1'b1;
         tspp_pkg::ST_FINISH: load_rsp = rsp_free;
         default: ;
      endcase
   end

   // head slot processing
   assign id_ok   = (id_ff != tspp_pkg::EMPTY_ID);
   assign hit     = (head.id == id_ff);
   assign occ     = (head.id != tspp_pkg::EMPTY_ID);
   assign pick_ok = (best_ff != tspp_pkg::NO_PRIO);

   always_comb begin
      tail_in    = head;
      flag_in    = flag_ff;
      best_in    = best_ff;
      best_id_in = best_id_ff;
      if (state_ff == tspp_pkg::ST_SCAN) begin
         case (op_ff)
            tspp_pkg::OP_ADD: begin
               if (id_ok && !occ && !flag_ff) begin
                  tail_in.id   = id_ff;
                  tail_in.prio = prio_ff;
                  flag_in      = 1'b1;
               end
            end
            tspp_pkg::OP_REMOVE: begin
               if (id_ok && hit) tail_in.id = tspp_pkg::EMPTY_ID;
            end
            tspp_pkg::OP_QUERY: begin
               if (id_ok && hit) flag_in = 1'b1;
            end
            tspp_pkg::OP_POP: begin
               if (occ && (head.prio < best_ff)) begin
                  best_in    = head.prio;
                  best_id_in = head.id;
               end
            end
            default: ;
         endcase
      end else if (state_ff == tspp_pkg::ST_CLEAR) begin
         if (pick_ok && (head.id == best_id_ff)) tail_in.id = tspp_pkg::EMPTY_ID;
      end
      any_in = any_ff || (tail_in.id != tspp_pkg::EMPTY_ID);
      // pop counts occupancy on the clearing pass only
      if ((state_ff == tspp_pkg::ST_SCAN) && last && (op_ff == tspp_pkg::OP_POP)) begin
         any_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tspp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            cnt_ff <= '0;
         end else if (shift) begin
            cnt_ff <= last ? '0 : cnt_ff + CNT_W'(1);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= tspp_pkg::op_type'(req_ch.opcode);
         id_ff   <= req_ch.task_id;
         prio_ff <= req_ch.task_priority;
         flag_ff <= 1'b0;
         any_ff  <= 1'b0;
         best_ff <= tspp_pkg::NO_PRIO;
      end else if (shift) begin
         flag_ff    <= flag_in;
         any_ff     <= any_in;
         best_ff    <= best_in;
         best_id_ff <= best_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_found_ff  <= (op_ff == tspp_pkg::OP_QUERY) && flag_ff;
         rsp_empty_ff  <= !any_ff;
         rsp_pvalid_ff <= (op_ff == tspp_pkg::OP_POP) && pick_ok;
         rsp_pid_ff    <= ((op_ff == tspp_pkg::OP_POP) && pick_ok) ? best_id_ff : '0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.table_empty  = rsp_empty_ff;
   assign rsp_ch.picked_valid = rsp_pvalid_ff;
   assign rsp_ch.picked_id    = rsp_pid_ff;

   `TSPP_ASSERT_NEXT(a_accept_scans, clock, reset, accept, state_ff == tspp_pkg::ST_SCAN, "accepted operation did not start a scan")
   `TSPP_ASSERT_NOW(a_pick_not_empty, clock, reset, rsp_ch.valid && rsp_ch.picked_valid, rsp_ch.picked_id != tspp_pkg::EMPTY_ID, "picked id is the empty marker")
   `TSPP_ASSERT_NOW(a_no_pick_zero, clock, reset, rsp_ch.valid && !rsp_ch.picked_valid, rsp_ch.picked_id == '0, "picked id nonzero without a pick")
   `TSPP_ASSERT_NOW(a_found_xor_pick, clock, reset, rsp_ch.valid, !(rsp_ch.found && rsp_ch.picked_valid), "found and pick in one result")

endmodule
